/* sv/svts_pkg.sv */
// ----------------------------------------------------------------------------
// Sparse value table search: shared package
// Types, codes and default constants used across the search block.
// ----------------------------------------------------------------------------
package svts_pkg;

  // Default sizes of the table storage.
  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_VALUE_WIDTH = 16;
  localparam int DEF_PROB_WIDTH  = 32;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration registers.
  localparam int CFG_DATA_W = 17;
  localparam logic [0:0] REG_CARDINALITY = 1'b0;
  localparam logic [0:0] REG_ENTRIES     = 1'b1;
  localparam logic [16:0] CARDINALITY_RESET = 17'h10000;
  localparam logic [8:0]  ENTRIES_RESET     = 9'd1;

  // Item actions.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ORDER = 2'd2;

  typedef struct packed {
    logic        action;
    logic [7:0]  entry_position;
    logic [15:0] symbol_value;
    logic [31:0] probability_word;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  match_position;
    logic [31:0] match_probability;
    logic [1:0]  status;
  } result_t;

  // What the front has decided an item needs from the back.
  typedef enum logic [1:0] {
    CMD_REPORT,  // result is known already, only the status is passed on
    CMD_WRITE,   // load at position zero, written without an order check
    CMD_LOAD,    // load that needs the order check against the entry before
    CMD_LOOKUP   // binary search over the used entries
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [1:0]  status;
    logic [7:0]  pos;
    logic [15:0] val;
    logic [31:0] prob;
    logic [8:0]  count;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LCHECK,
    S_BOUND,
    S_PROBE,
    S_DELIVER
  } back_state_t;

  // A result that carries nothing but a status.
  function automatic result_t status_only(logic [1:0] st);
    result_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

endpackage

/* sv/svts_front.sv */
// ----------------------------------------------------------------------------
// Sparse value table search: front
// Holds the configuration registers, accepts items and classifies them into
// commands for the back.
// ----------------------------------------------------------------------------
module svts_front #(
  parameter int TABLE_DEPTH = svts_pkg::DEF_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [0:0]                       cfg_index,
  input  logic [svts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  svts_pkg::item_t                  item,
  output logic                             push,
  output svts_pkg::cmd_t                   push_cmd,
  input  logic                             full
);

  logic [16:0] cardinality;
  logic [8:0]  entries_in_use;
  logic [8:0]  used;

  always_ff @(posedge clk) begin
    if (rst) begin
      cardinality    <= svts_pkg::CARDINALITY_RESET;
      entries_in_use <= svts_pkg::ENTRIES_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        svts_pkg::REG_CARDINALITY: cardinality    <= cfg_data;
        svts_pkg::REG_ENTRIES:     entries_in_use <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // The searched count saturates at the table depth.
  assign used = (32'(entries_in_use) > TABLE_DEPTH) ? 9'(TABLE_DEPTH) : entries_in_use;

  assign item_stall = full;
  assign push       = item_valid && !full;

  always_comb begin
    push_cmd        = '0;
    push_cmd.kind   = svts_pkg::CMD_REPORT;
    push_cmd.status = svts_pkg::ST_OK;
    push_cmd.pos    = item.entry_position;
    push_cmd.val    = item.symbol_value;
    push_cmd.prob   = item.probability_word;
    push_cmd.count  = used;
    if ({1'b0, item.symbol_value} >= cardinality) begin
      push_cmd.status = svts_pkg::ST_RANGE;
    end else if (item.action == svts_pkg::ACT_LOAD) begin
      if (32'(item.entry_position) >= TABLE_DEPTH) begin
        push_cmd.kind = svts_pkg::CMD_REPORT;
      end else if (item.entry_position == 8'd0) begin
        push_cmd.kind = svts_pkg::CMD_WRITE;
      end else begin
        push_cmd.kind = svts_pkg::CMD_LOAD;
      end
    end else if (used != 9'd0) begin
      push_cmd.kind = svts_pkg::CMD_LOOKUP;
    end
  end

endmodule

/* sv/svts_queue.sv */
// ----------------------------------------------------------------------------
// Sparse value table search: command queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module svts_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  svts_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output svts_pkg::cmd_t head
);

  localparam int QD  = svts_pkg::QUEUE_DEPTH;
  localparam int PW  = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  svts_pkg::cmd_t slots [QD];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [QCW-1:0] count;

  assign full       = (count == QCW'(QD));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QD - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QD - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

/* sv/svts_back.sv */
// ----------------------------------------------------------------------------
// Sparse value table search: back
// Owns the table memories, carries out loads and binary searches one command
// at a time and holds the result register.
// ----------------------------------------------------------------------------
module svts_back #(
  parameter int TABLE_DEPTH = svts_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = svts_pkg::DEF_VALUE_WIDTH,
  parameter int PROB_WIDTH  = svts_pkg::DEF_PROB_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  svts_pkg::cmd_t    head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output svts_pkg::result_t result
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = AW + 1;
  localparam int VW   = VALUE_WIDTH;
  localparam int PW   = PROB_WIDTH;
  localparam int CMPW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;

  logic [VW-1:0] value_mem [TABLE_DEPTH];
  logic [PW-1:0] prob_mem  [TABLE_DEPTH];

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] rd_val;
  logic [PW-1:0] rd_prob;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [VW-1:0] wr_val;
  logic [PW-1:0] wr_prob;

  svts_pkg::back_state_t state, state_next;
  logic [15:0]           key, key_next;
  logic [31:0]           prob, prob_next;
  logic [AW-1:0]         pos, pos_next;
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi_excl, hi_excl_next;
  logic [AW-1:0]         mid, mid_next;
  svts_pkg::result_t     res, res_next;
  logic                  out_load;
  logic                  out_free;

  logic            key_lt;
  logic            key_gt;
  logic [CW-1:0]   lo_upd;
  logic [CW-1:0]   hi_upd;
  logic [CW:0]     mid_sum;
  logic [AW-1:0]   mid_upd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_val;
      prob_mem[wr_addr]  <= wr_prob;
    end
    if (rd_en) begin
      rd_val  <= value_mem[rd_addr];
      rd_prob <= prob_mem[rd_addr];
    end
  end

  assign out_free = !result_valid || !result_stall;

  // One probe step: compare against the entry read at mid and narrow the
  // half-open interval [lo, hi_excl).
  assign key_lt  = CMPW'(key) < CMPW'(rd_val);
  assign key_gt  = CMPW'(key) > CMPW'(rd_val);
  assign lo_upd  = key_gt ? (CW'(mid) + CW'(1)) : lo;
  assign hi_upd  = key_lt ? CW'(mid) : hi_excl;
  assign mid_sum = (CW + 1)'(lo_upd) + (CW + 1)'(hi_upd) - (CW + 1)'(1);
  assign mid_upd = mid_sum[AW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    key     <= key_next;
    prob    <= prob_next;
    pos     <= pos_next;
    lo      <= lo_next;
    hi_excl <= hi_excl_next;
    mid     <= mid_next;
    res     <= res_next;
  end

  always_comb begin
    state_next   = state;
    key_next     = key;
    prob_next    = prob;
    pos_next     = pos;
    lo_next      = lo;
    hi_excl_next = hi_excl;
    mid_next     = mid;
    res_next     = res;
    pop          = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = mid;
    wr_en        = 1'b0;
    wr_addr      = pos;
    wr_val       = VW'(key);
    wr_prob      = PW'(prob);
    out_load     = 1'b0;
    case (state)
      svts_pkg::S_IDLE: begin
        if (head_valid) begin
          pop       = 1'b1;
          key_next  = head.val;
          prob_next = head.prob;
          pos_next  = AW'(head.pos);
          case (head.kind)
            svts_pkg::CMD_REPORT: begin
              res_next   = svts_pkg::status_only(head.status);
              state_next = svts_pkg::S_DELIVER;
            end
            svts_pkg::CMD_WRITE: begin
              wr_en      = 1'b1;
              wr_addr    = AW'(head.pos);
              wr_val     = VW'(head.val);
              wr_prob    = PW'(head.prob);
              res_next   = svts_pkg::status_only(svts_pkg::ST_OK);
              state_next = svts_pkg::S_DELIVER;
            end
            svts_pkg::CMD_LOAD: begin
              rd_en      = 1'b1;
              rd_addr    = AW'(head.pos) - AW'(1);
              state_next = svts_pkg::S_LCHECK;
            end
            svts_pkg::CMD_LOOKUP: begin
              rd_en        = 1'b1;
              rd_addr      = AW'(head.count - 9'd1);
              lo_next      = '0;
              hi_excl_next = CW'(head.count);
              mid_next     = AW'(head.count - 9'd1) >> 1;
              state_next   = svts_pkg::S_BOUND;
            end
            default: state_next = svts_pkg::S_IDLE;
          endcase
        end
      end
      svts_pkg::S_LCHECK: begin
        if (VW'(key) <= rd_val) begin
          res_next = svts_pkg::status_only(svts_pkg::ST_ORDER);
        end else begin
          wr_en    = 1'b1;
          res_next = svts_pkg::status_only(svts_pkg::ST_OK);
        end
        state_next = svts_pkg::S_DELIVER;
      end
      svts_pkg::S_BOUND: begin
        if (CMPW'(key) > CMPW'(rd_val)) begin
          res_next   = svts_pkg::status_only(svts_pkg::ST_OK);
          state_next = svts_pkg::S_DELIVER;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = mid;
          state_next = svts_pkg::S_PROBE;
        end
      end
      svts_pkg::S_PROBE: begin
        if (!key_lt && !key_gt) begin
          res_next                   = svts_pkg::status_only(svts_pkg::ST_OK);
          res_next.found             = 1'b1;
          res_next.match_position    = 8'(mid);
          res_next.match_probability = 32'(rd_prob);
          state_next                 = svts_pkg::S_DELIVER;
        end else if (lo_upd < hi_upd) begin
          lo_next      = lo_upd;
          hi_excl_next = hi_upd;
          mid_next     = mid_upd;
          rd_en        = 1'b1;
          rd_addr      = mid_upd;
        end else begin
          res_next   = svts_pkg::status_only(svts_pkg::ST_OK);
          state_next = svts_pkg::S_DELIVER;
        end
      end
      svts_pkg::S_DELIVER: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = svts_pkg::S_IDLE;
        end
      end
      default: state_next = svts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= res;
    end
  end

  // The search interval is never empty while a probe is pending.
  a_probe_interval: assert property (@(posedge clk) disable iff (rst)
    state == svts_pkg::S_PROBE |-> lo < hi_excl)
    else $error("probe pending with an empty search interval");

  // The probe position lies inside the search interval.
  a_probe_mid: assert property (@(posedge clk) disable iff (rst)
    state == svts_pkg::S_PROBE |-> (CW'(mid) >= lo) && (CW'(mid) < hi_excl))
    else $error("probe position outside the search interval");

  // A hit always reports a clean status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.found |-> result.status == svts_pkg::ST_OK)
    else $error("hit reported with an error status");

  // A new result only appears after the delivery step.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == svts_pkg::S_DELIVER)
    else $error("result raised outside the delivery step");

endmodule

/* sv/sparse_value_table_search.sv */
// ----------------------------------------------------------------------------
// Sparse value table search
// Sorted table of symbol values with probability words, loaded entry by
// entry and searched by binary search.
// ----------------------------------------------------------------------------
// The block takes one transaction on the item channel for each load or
// lookup and returns exactly one transaction on the result channel for it,
// in order. The front checks each item against the cardinality, decides
// what it needs and places it in a two-entry queue; the back then works
// through the queue one command at a time against a single-read,
// single-write table memory with registered read data. An item whose result
// is settled by the front (a value out of range, a load beyond the table,
// a lookup with no entries in use) and a load at position zero go from the
// idle step straight to delivery; a checked load reads the entry before,
// compares and writes, then delivers. A lookup reads the last entry in use
// as a bound check and, unless the key lies above it, makes at most
// ceil(log2(n + 1)) probes for n entries in use before it delivers; the
// memory read port serves one probe per cycle. The result register lets the
// back move on while a result waits to be taken, and the queue keeps the
// item channel open while the back is busy. The table memories have no
// reset: a lookup or an order check that reaches an entry never loaded
// returns an undefined value. The user must write configuration only while
// the block is idle, which the block does not enforce. Register 0 is the
// cardinality, register 1 the entries in use (searched up to table depth).
// ----------------------------------------------------------------------------
module sparse_value_table_search #(
  parameter int TABLE_DEPTH = svts_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = svts_pkg::DEF_VALUE_WIDTH,
  parameter int PROB_WIDTH  = svts_pkg::DEF_PROB_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [0:0]                      cfg_index,
  input  logic [svts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  svts_pkg::item_t                 item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output svts_pkg::result_t               result
);

  // Commands flow from the front through the queue to the back.
  logic           push;
  svts_pkg::cmd_t push_cmd;
  logic           full;
  logic           pop;
  logic           head_valid;
  svts_pkg::cmd_t head;

  svts_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full)
  );

  svts_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back owns the table and the result register.
  svts_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .PROB_WIDTH  (PROB_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* test/sparse_value_table_search_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse value table search: self-checking testbench
// Loads and searches the sorted symbol table through the item channel and
// checks every result transaction against an in-bench model of the table.
// ----------------------------------------------------------------------------
// A short table of directed steps comes first. It covers the reset settings,
// the order and range errors, a cardinality of zero, no entries in use, and a
// table made unsorted by overwriting an entry. Random phases follow. Each
// phase sets the number of entries in use, most also the cardinality, while
// the block is idle, then sends a mix of well-formed loads, lookups of stored
// values and noise. Loads and lookups are only generated where every table
// entry that the block could read has already been written, because the
// table memories have no reset.
// ----------------------------------------------------------------------------
module sparse_value_table_search_tb;

  // One step of the directed part: either a register write or an item.
  // Where typed is set, want holds the result as read off by hand;
  // otherwise the result comes from the table model.
  typedef struct packed {
    logic              is_cfg;
    logic [0:0]        reg_idx;
    logic [16:0]       reg_val;
    svts_pkg::item_t   it;
    logic              typed;
    svts_pkg::result_t want;
  } step_row_t;

  localparam svts_pkg::result_t EMPTY_OK   = '0;
  localparam svts_pkg::result_t RANGE_FAIL =
    svts_pkg::result_t'{1'b0, 8'd0, 32'd0, svts_pkg::ST_RANGE};
  localparam svts_pkg::result_t ORDER_FAIL =
    svts_pkg::result_t'{1'b0, 8'd0, 32'd0, svts_pkg::ST_ORDER};

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              cfg_write    = 1'b0;
  logic [0:0]        cfg_index    = '0;
  logic [16:0]       cfg_data     = '0;
  logic              item_valid   = 1'b0;
  logic              item_stall;
  svts_pkg::item_t   item_bus     = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  svts_pkg::result_t result_bus;

  // Model of the table and of the two registers.
  logic [15:0] value_store [256];
  logic [31:0] prob_store  [256];
  int          filled_count = 0;  // entries 0 .. filled_count-1 are written
  logic [16:0] card_reg     = svts_pkg::CARDINALITY_RESET;
  logic [8:0]  in_use_reg   = svts_pkg::ENTRIES_RESET;

  svts_pkg::result_t expected_results [$];
  int                mismatch_count   = 0;
  bit                idle_on          = 1'b0;
  int                hold_off_cycles  = 0;

  step_row_t   steps [27];

  sparse_value_table_search DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one accepted item and applies any load to the
  // model table. Entries are written only at a position whose predecessor
  // is already written, so the written part of the table is always a prefix.
  function automatic svts_pkg::result_t table_outcome(svts_pkg::item_t it);
    svts_pkg::result_t r;
    int      n;
    int      lo;
    int      hi;
    int      mid;
    int      hit_at;
    r = '0;
    if ({1'b0, it.symbol_value} >= card_reg) begin
      // The range check comes first for both actions.
      r.status = svts_pkg::ST_RANGE;
    end else if (it.action == svts_pkg::ACT_LOAD) begin
      if (it.entry_position != 8'd0 &&
          it.symbol_value <= value_store[it.entry_position - 8'd1]) begin
        r.status = svts_pkg::ST_ORDER;
      end else begin
        value_store[it.entry_position] = it.symbol_value;
        prob_store[it.entry_position]  = it.probability_word;
        if (int'(it.entry_position) == filled_count)
          filled_count++;
      end
    end else begin
      n = (in_use_reg > 9'd256) ? 256 : int'(in_use_reg);
      if (n != 0 && it.symbol_value <= value_store[8'(n - 1)]) begin
        // Same probe order as on a sorted table, whatever the contents.
        lo     = 0;
        hi     = n - 1;
        hit_at = -1;
        while (lo <= hi && hit_at < 0) begin
          mid = (lo + hi) / 2;
          if (it.symbol_value < value_store[8'(mid)])
            hi = mid - 1;
          else if (it.symbol_value > value_store[8'(mid)])
            lo = mid + 1;
          else
            hit_at = mid;
        end
        if (hit_at >= 0) begin
          r.found             = 1'b1;
          r.match_position    = 8'(hit_at);
          r.match_probability = prob_store[8'(hit_at)];
        end
      end
    end
    return r;
  endfunction

  // Draws one random item that never makes the block read an unwritten
  // entry: a lookup inside the range needs all entries in use written, and
  // a load inside the range needs the entry before its position written.
  function automatic svts_pkg::item_t make_item();
    svts_pkg::item_t it;
    int    n;
    int    k;
    int    base;
    int    v;
    int    top_pos;
    int    pos;
    n = (in_use_reg > 9'd256) ? 256 : int'(in_use_reg);
    it.probability_word = $urandom();
    it.entry_position   = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 50 && n <= filled_count) begin
      it.action = svts_pkg::ACT_LOOKUP;
      k    = (n > 0) ? $urandom_range(0, n - 1) : 0;
      base = (n > 0) ? int'(value_store[8'(k)]) : $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: v = base;
        6: v = $urandom_range(0, 1) ? base + 1 : base - 1;
        7: v = $urandom_range(0, 65535);
        8: begin
          case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 65535;
            2: v = int'(card_reg) - 1;
            default: v = int'(card_reg);
          endcase
        end
        default: v = (n > 0) ? int'(value_store[8'(n - 1)]) + 1 : base;
      endcase
      it.symbol_value = 16'(v);
    end else begin
      it.action = svts_pkg::ACT_LOAD;
      top_pos = (filled_count > 255) ? 255 : filled_count;
      pos = $urandom_range(0, 1) ? top_pos : $urandom_range(0, top_pos);
      if (pos == 0)
        v = $urandom_range(0, 300);
      else
        v = int'(value_store[8'(pos - 1)]) + $urandom_range(1, 255);
      if (v > 65535)
        v = 65535;
      if ($urandom_range(0, 4) == 0)
        v = $urandom_range(0, 65535);
      it.entry_position = 8'(pos);
      // Now and then a value out of range at any position: the range check
      // wins, so the entry before it is never read.
      if (card_reg <= 17'd65535 && $urandom_range(0, 9) == 0) begin
        it.entry_position = 8'($urandom_range(0, 255));
        v = $urandom_range(int'(card_reg), 65535);
      end
      it.symbol_value = 16'(v);
    end
    return it;
  endfunction

  function automatic step_row_t item_row(svts_pkg::item_t it, logic typed,
                                         svts_pkg::result_t want);
    step_row_t r;
    r       = '0;
    r.it    = it;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic step_row_t reg_row(logic [0:0] idx, logic [16:0] data);
    step_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = data;
    return r;
  endfunction

  // Offers one item, possibly after a random gap, and holds it until the
  // block takes it. The expected result is queued at the accepting edge.
  task automatic offer(svts_pkg::item_t it, logic typed, svts_pkg::result_t want);
    svts_pkg::result_t predicted;
    int      gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk) item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item_bus   <= it;
    do @(posedge clk); while (item_stall);
    predicted = table_outcome(it);
    expected_results.push_back(typed ? want : predicted);
  endtask

  // Drops the item valid and waits for every outstanding result. Every item
  // yields exactly one result, so an empty queue means the block is idle.
  task automatic settle();
    @(negedge clk) item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] data);
    settle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk) cfg_write <= 1'b0;
    if (idx == svts_pkg::REG_CARDINALITY)
      card_reg = data;
    else
      in_use_reg = data[8:0];
  endtask

  task automatic run_mixed(int count);
    repeat (count) offer(make_item(), 1'b0, '0);
  endtask

  // Writes every entry of the table in ascending order from a random base.
  task automatic refill();
    svts_pkg::item_t it;
    int    v;
    v = $urandom_range(0, 40);
    for (int p = 0; p < 256; p++) begin
      it.action           = svts_pkg::ACT_LOAD;
      it.entry_position   = 8'(p);
      it.symbol_value     = 16'(v);
      it.probability_word = $urandom();
      offer(it, 1'b0, '0);
      v += $urandom_range(1, 250);
    end
  endtask

  task automatic flag_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want_v, got_v);
  endtask

  // Result checker: every accepted result transaction is matched against the
  // oldest outstanding expectation, field by field.
  always @(posedge clk) begin
    svts_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result with nothing outstanding", '0, 32'(result_bus.status));
      end else begin
        want = expected_results.pop_front();
        if (result_bus.found !== want.found)
          flag_mismatch("found", 32'(want.found), 32'(result_bus.found));
        if (result_bus.match_position !== want.match_position)
          flag_mismatch("match_position", 32'(want.match_position),
                        32'(result_bus.match_position));
        if (result_bus.match_probability !== want.match_probability)
          flag_mismatch("match_probability", want.match_probability,
                        result_bus.match_probability);
        if (result_bus.status !== want.status)
          flag_mismatch("status", 32'(want.status), 32'(result_bus.status));
      end
    end
  end

  // Receiver: random stall bursts while idling is allowed, and one long
  // hold-off on request so that the block backs up and stalls its input.
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        burst           = hold_off_cycles;
        hold_off_cycles = 0;
        result_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 16);
        result_stall <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Hard limit on the length of the run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    steps = '{
      // Reset settings: cardinality 65536, one entry in use.
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd0, 16'd0, 32'hFFFF_FFFF},
               1'b1, EMPTY_OK),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'hFF, 16'd0, 32'd0}, 1'b1,
               svts_pkg::result_t'{1'b1, 8'd0, 32'hFFFF_FFFF, svts_pkg::ST_OK}),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'hFFFF, 32'hFFFF_FFFF},
               1'b1, EMPTY_OK),
      // A load that does not climb above the entry before it is refused.
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd1, 16'd0, 32'd7},
               1'b1, ORDER_FAIL),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd1, 16'hFFFF, 32'd0},
               1'b1, EMPTY_OK),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd2, 16'hFFFF, 32'd9},
               1'b1, ORDER_FAIL),
      reg_row(svts_pkg::REG_ENTRIES, 17'd2),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'hFFFF, 32'd0}, 1'b1,
               svts_pkg::result_t'{1'b1, 8'd1, 32'd0, svts_pkg::ST_OK}),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd1, 32'd0}, 1'b0, '0),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd1, 16'd100, 32'hA5A5_A5A5},
               1'b0, '0),
      // Range errors win over the order check, even where the entry before
      // the position was never written.
      reg_row(svts_pkg::REG_CARDINALITY, 17'd100),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd2, 16'd100, 32'd1},
               1'b1, RANGE_FAIL),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd255, 16'hFFFF, 32'd1},
               1'b1, RANGE_FAIL),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd100, 32'd0},
               1'b1, RANGE_FAIL),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd99, 32'd0}, 1'b0, '0),
      // A cardinality of zero rejects every value.
      reg_row(svts_pkg::REG_CARDINALITY, 17'd0),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd0, 32'd0},
               1'b1, RANGE_FAIL),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd0, 16'd0, 32'd0},
               1'b1, RANGE_FAIL),
      // With no entries in use a lookup simply misses.
      reg_row(svts_pkg::REG_CARDINALITY, 17'h1FFFF),
      reg_row(svts_pkg::REG_ENTRIES, 17'd0),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'hFFFF, 32'd0},
               1'b1, EMPTY_OK),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd0, 32'd0},
               1'b1, EMPTY_OK),
      // Overwriting entry zero with a larger value leaves the table unsorted.
      reg_row(svts_pkg::REG_ENTRIES, 17'd2),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOAD, 8'd0, 16'd200, 32'h1234_5678},
               1'b0, '0),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd100, 32'd0}, 1'b0, '0),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd200, 32'd0}, 1'b0, '0),
      item_row(svts_pkg::item_t'{svts_pkg::ACT_LOOKUP, 8'd0, 16'd0, 32'd0}, 1'b0, '0)
    };

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_cfg)
        write_reg(steps[i].reg_idx, steps[i].reg_val);
      else
        offer(steps[i].it, steps[i].typed, steps[i].want);
    end

    idle_on = 1'b1;

    // Small search window while the table grows from its first two entries.
    write_reg(svts_pkg::REG_CARDINALITY, 17'h10000);
    write_reg(svts_pkg::REG_ENTRIES, 17'd2);
    run_mixed(100);

    // Full table, with one long hold-off on the result side at the start.
    refill();
    write_reg(svts_pkg::REG_ENTRIES, 17'd256);
    hold_off_cycles = 300;
    run_mixed(200);

    // Widest cardinality, and an entry count beyond the table depth.
    write_reg(svts_pkg::REG_CARDINALITY, 17'h1FFFF);
    write_reg(svts_pkg::REG_ENTRIES, 17'd511);
    run_mixed(150);

    write_reg(svts_pkg::REG_CARDINALITY, 17'($urandom_range(1000, 60000)));
    write_reg(svts_pkg::REG_ENTRIES, 17'($urandom_range(1, 256)));
    run_mixed(150);

    write_reg(svts_pkg::REG_CARDINALITY, 17'd1);
    write_reg(svts_pkg::REG_ENTRIES, 17'd1);
    run_mixed(60);

    write_reg(svts_pkg::REG_CARDINALITY, 17'hFFFF);
    write_reg(svts_pkg::REG_ENTRIES, 17'd0);
    run_mixed(60);

    write_reg(svts_pkg::REG_CARDINALITY, 17'h10000);
    refill();
    write_reg(svts_pkg::REG_ENTRIES, 17'($urandom_range(100, 256)));
    run_mixed(150);

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    write_reg(svts_pkg::REG_ENTRIES, 17'd256);
    run_mixed(150);

    settle();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
